### sv/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// shared constants for the three-component vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;
   localparam int COMPONENT_BITS = 24;
   localparam int FRACTION_BITS  = 14;
   localparam int FIELD_BITS     = 24;
   localparam int OUT_BITS       = 16;
   localparam int OUT_MAX_MAG    = 32767;
endpackage

### sv/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// scales a signed 3-vector to unit length in signed fixed point
// ----------------------------------------------------------------------------
//  channel   ports                            handshake
//  request   req_x_in req_y_in req_z_in       start, taken when busy is low
//  result    rsp_x_out rsp_y_out rsp_z_out    rsp_valid, one cycle strobe
//            rsp_zero_length
//
//  one request per cycle; busy is always low
//  rsp_valid follows the accepting edge through three input stages,
//  COMPONENT_BITS+1 square root stages, max(OUT_BITS, FRACTION_BITS)+1
//  quotient stages and one output register
//  synchronous reset clears all valid bits; results cannot be stalled
// ----------------------------------------------------------------------------
module vector3_normalize #(
   parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS,
   parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [vn_pkg::FIELD_BITS-1:0] req_x_in,
   input  logic signed [vn_pkg::FIELD_BITS-1:0] req_y_in,
   input  logic signed [vn_pkg::FIELD_BITS-1:0] req_z_in,
   output logic                                 rsp_valid,
   output logic signed [vn_pkg::OUT_BITS-1:0]   rsp_x_out,
   output logic signed [vn_pkg::OUT_BITS-1:0]   rsp_y_out,
   output logic signed [vn_pkg::OUT_BITS-1:0]   rsp_z_out,
   output logic                                 rsp_zero_length
);
   localparam int CB   = COMPONENT_BITS;
   localparam int SQB  = 2 * CB;
   localparam int SUMB = SQB + 2;
   localparam int LB   = SUMB / 2;
   localparam int NB   = CB + FRACTION_BITS;
   localparam int OB   = vn_pkg::OUT_BITS;
   localparam int QW   = ((OB > FRACTION_BITS) ? OB : FRACTION_BITS) + 1;
   localparam int DLAT = QW + 1;

   assign busy = 1'b0;

   // stage 1: magnitudes and signs
   logic          v1_ff;
   logic [CB-1:0] m1_ff [3];
   logic [2:0]    s1_ff;
   logic [CB-1:0] raw_in [3];
   always_comb begin
      raw_in[0] = req_x_in[CB-1:0];
      raw_in[1] = req_y_in[CB-1:0];
      raw_in[2] = req_z_in[CB-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      for (int i = 0; i < 3; i++) begin
         s1_ff[i] <= raw_in[i][CB-1];
         m1_ff[i] <= raw_in[i][CB-1] ? (~raw_in[i] + 1'b1) : raw_in[i];
      end
   end
   // most negative value: two's complement wraps to the sign bit, as desired

   // stage 2: squares
   logic           v2_ff;
   logic [CB-1:0]  m2_ff [3];
   logic [2:0]     s2_ff;
   logic [SQB-1:0] sq2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      s2_ff <= s1_ff;
      for (int i = 0; i < 3; i++) begin
         m2_ff[i]  <= m1_ff[i];
         sq2_ff[i] <= SQB'(m1_ff[i]) * SQB'(m1_ff[i]);
      end
   end

   // stage 3: sum of squares
   logic            v3_ff;
   logic [CB-1:0]   m3_ff [3];
   logic [2:0]      s3_ff;
   logic [SUMB-1:0] sum3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      s3_ff   <= s2_ff;
      m3_ff   <= m2_ff;
      sum3_ff <= SUMB'(sq2_ff[0]) + SUMB'(sq2_ff[1]) + SUMB'(sq2_ff[2]);
   end

   // square root pipeline, one result bit per stage
   logic [LB:0]     sv_ff;
   logic [SUMB-1:0] sn_ff [LB+1];
   logic [LB+1:0]   sr_ff [LB+1];
   logic [LB-1:0]   sq_ff [LB+1];
   logic [CB-1:0]   sm_ff [LB+1][3];
   logic [2:0]      ss_ff [LB+1];
   logic [LB:0]     sz_ff;
   always_comb begin
      sv_ff[0] = v3_ff;
      sn_ff[0] = sum3_ff;
      sr_ff[0] = '0;
      sq_ff[0] = '0;
      sm_ff[0] = m3_ff;
      ss_ff[0] = s3_ff;
      sz_ff[0] = (sum3_ff == '0);
   end
   for (genvar k = 0; k < LB; k++) begin : g_sqrt
      localparam int P = SUMB - 2 - 2 * k;
      logic [LB+1:0] trial_in;
      logic [LB+2:0] diff_in;
      always_comb begin
         trial_in = {sr_ff[k][LB-1:0], sn_ff[k][P+1], sn_ff[k][P]};
         diff_in  = {1'b0, trial_in} - {1'b0, sq_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else begin
            sv_ff[k+1] <= sv_ff[k];
         end
         sn_ff[k+1] <= sn_ff[k];
         sm_ff[k+1] <= sm_ff[k];
         ss_ff[k+1] <= ss_ff[k];
         sz_ff[k+1] <= sz_ff[k];
         if (!diff_in[LB+2]) begin
            sr_ff[k+1] <= diff_in[LB+1:0];
            sq_ff[k+1] <= {sq_ff[k][LB-2:0], 1'b1};
         end else begin
            sr_ff[k+1] <= trial_in;
            sq_ff[k+1] <= {sq_ff[k][LB-2:0], 1'b0};
         end
      end
   end

   // dividers, one per component
   logic [OB-1:0] q_out [3];
   logic [2:0]    dv_out;
   logic [LB-1:0] den_in;
   always_comb den_in = sz_ff[LB] ? LB'(1) : sq_ff[LB];
   for (genvar c = 0; c < 3; c++) begin : g_div
      vn_divider #(
         .NUM_BITS(NB),
         .DEN_BITS(LB),
         .Q_BITS  (OB),
         .SAT     (1 << FRACTION_BITS)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .valid_in (sv_ff[LB]),
         .num_in   ({sm_ff[LB][c], FRACTION_BITS'(0)}),
         .den_in   (den_in),
         .valid_out(dv_out[c]),
         .quot_out (q_out[c])
      );
   end

   // sign and zero flag travel alongside the dividers
   logic [2:0] ds_ff [DLAT+1];
   logic       dz_ff [DLAT+1];
   always_comb begin
      ds_ff[0] = ss_ff[LB];
      dz_ff[0] = sz_ff[LB];
   end
   for (genvar d = 0; d < DLAT; d++) begin : g_side
      always_ff @(posedge clock) begin
         ds_ff[d+1] <= ds_ff[d];
         dz_ff[d+1] <= dz_ff[d];
      end
   end

   logic [OB-1:0] res_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dz_ff[DLAT]) res_in[i] = '0;
         else if (ds_ff[DLAT][i]) res_in[i] = ~q_out[i] + 1'b1;
         else res_in[i] = q_out[i];
      end
   end

   assign rsp_valid       = dv_out[0];
   assign rsp_x_out       = res_in[0];
   assign rsp_y_out       = res_in[1];
   assign rsp_z_out       = res_in[2];
   assign rsp_zero_length = dz_ff[DLAT];
endmodule

### sv/vn_divider.sv
// ----------------------------------------------------------------------------
// vn_divider
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
module vn_divider #(
   parameter int NUM_BITS = 38,
   parameter int DEN_BITS = 24,
   parameter int Q_BITS   = 16,
   parameter int SAT      = 16384
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  logic [NUM_BITS-1:0] num_in,
   input  logic [DEN_BITS-1:0] den_in,
   output logic                valid_out,
   output logic [Q_BITS-1:0]   quot_out
);
   // quotient never exceeds SAT, so QB quotient bits are enough
   localparam int QB = ((Q_BITS > $clog2(SAT)) ? Q_BITS : $clog2(SAT)) + 1;
   localparam int RB = DEN_BITS + 1;

   logic [QB:0]          v_ff;
   logic [NUM_BITS-1:0]  n_ff [QB+1];
   logic [DEN_BITS-1:0]  d_ff [QB+1];
   logic [RB-1:0]        r_ff [QB+1];
   logic [QB-1:0]        q_ff [QB+1];
   logic [Q_BITS-1:0]    out_ff;
   logic                 vout_ff;

   // numerator bits above the quotient width seed the remainder
   always_comb begin
      v_ff[0] = valid_in;
      n_ff[0] = num_in;
      d_ff[0] = den_in;
      r_ff[0] = RB'(num_in >> QB);
      q_ff[0] = '0;
   end

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int SH = QB - 1 - s;
      logic [RB:0]         trial_in;
      logic [RB:0]         diff_in;
      logic                nbit_in;
      always_comb begin
         nbit_in  = (SH < NUM_BITS) ? n_ff[s][SH] : 1'b0;
         trial_in = {r_ff[s], nbit_in};
         diff_in  = trial_in - {2'b00, d_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
         n_ff[s+1] <= n_ff[s];
         d_ff[s+1] <= d_ff[s];
         if (!diff_in[RB]) begin
            r_ff[s+1] <= diff_in[RB-1:0];
            q_ff[s+1] <= {q_ff[s][QB-2:0], 1'b1};
         end else begin
            r_ff[s+1] <= trial_in[RB-1:0];
            q_ff[s+1] <= {q_ff[s][QB-2:0], 1'b0};
         end
      end
   end

   logic [QB-1:0] sat_in;
   always_comb begin
      sat_in = q_ff[QB];
      if (sat_in > QB'(SAT)) sat_in = QB'(SAT);
      if (sat_in > QB'(vn_pkg::OUT_MAX_MAG)) sat_in = QB'(vn_pkg::OUT_MAX_MAG);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else begin
         vout_ff <= v_ff[QB];
      end
      out_ff <= sat_in[Q_BITS-1:0];
   end

   assign valid_out = vout_ff;
   assign quot_out  = out_ff;
endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for vector3_normalize: random and directed vectors are
// driven through the start/busy request port, each result strobe is compared
// field by field against a fixed-point normalization predictor
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = vn_pkg::COMPONENT_BITS;
   localparam int FB = vn_pkg::FRACTION_BITS;
   localparam int FW = vn_pkg::FIELD_BITS;
   localparam int OW = vn_pkg::OUT_BITS;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FW-1:0] x;
      logic [FW-1:0] y;
      logic [FW-1:0] z;
   } vec_in_t;

   typedef struct packed {
      logic [OW-1:0] x;
      logic [OW-1:0] y;
      logic [OW-1:0] z;
      logic          zero;
   } unit_vec_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [FW-1:0] req_x_in = '0, req_y_in = '0, req_z_in = '0;
   logic rsp_valid, rsp_zero_length;
   logic signed [OW-1:0] rsp_x_out, rsp_y_out, rsp_z_out;

   vec_in_t   pending_vecs[$];
   unit_vec_t expected_units[$];
   int        errors = 0;
   int        cycles = 0;
   int        gap = 0;
   bit        drain_hold = 0;
   bit        stim_done = 0;

   vector3_normalize dut (.*);

   initial forever #2 clock = ~clock;

   function automatic logic [63:0] magnitude(input logic [FW-1:0] raw, output bit neg);
      logic [63:0] v;
      v = 64'(raw[CB-1:0]);
      neg = raw[CB-1];
      if (neg) v = (64'(1) << CB) - v;
      return v;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic unit_vec_t normalize(input vec_in_t v);
      logic [63:0] m[3], sum, len, q;
      bit          n[3];
      logic [OW-1:0] o[3];
      unit_vec_t   u;
      m[0] = magnitude(v.x, n[0]);
      m[1] = magnitude(v.y, n[1]);
      m[2] = magnitude(v.z, n[2]);
      sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
      if (sum == 0) begin
         u = '0;
         u.zero = 1;
         return u;
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] << FB) / len;
         if (q > (64'(1) << FB)) q = 64'(1) << FB;
         if (q > vn_pkg::OUT_MAX_MAG) q = vn_pkg::OUT_MAX_MAG;
         o[i] = n[i] ? OW'(-q) : OW'(q);
      end
      u.x = o[0];
      u.y = o[1];
      u.z = o[2];
      u.zero = 0;
      return u;
   endfunction

   function automatic logic [FW-1:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return FW'($urandom_range(0, 3)) - 2;
         1: return {1'b1, {(FW-1){1'b0}}};
         2: return {1'b0, {(FW-1){1'b1}}};
         3: return FW'($urandom_range(0, 255)) - 128;
         default: return FW'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         start <= 0;
      end else if (start && !busy && gap == 0 && pending_vecs.size() == 0) begin
         start <= 0;
      end else if (!(start && busy)) begin
         if (drain_hold && !start && expected_units.size() == 0) drain_hold <= 0;
         if (gap > 0 || (drain_hold && (start || expected_units.size() != 0))
             || pending_vecs.size() == 0) begin
            if (gap > 0) gap <= gap - 1;
            start <= 0;
         end else begin
            vec_in_t v;
            v = pending_vecs.pop_front();
            req_x_in <= v.x;
            req_y_in <= v.y;
            req_z_in <= v.z;
            start <= 1;
            if (pending_vecs.size() == 700) drain_hold <= 1;
            case ($urandom_range(0, 19))
               0: gap <= $urandom_range(10, 60);
               1, 2, 3: gap <= $urandom_range(1, 3);
               default: gap <= 0;
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_units.push_back(normalize({req_x_in, req_y_in, req_z_in}));
         if (rsp_valid) begin
            if (expected_units.size() == 0) begin
               errors++;
               $display("%0t unexpected result x=%0d y=%0d z=%0d zero=%0b", $realtime,
                        rsp_x_out, rsp_y_out, rsp_z_out, rsp_zero_length);
            end else begin
               unit_vec_t e;
               e = expected_units.pop_front();
               if ({rsp_x_out, rsp_y_out, rsp_z_out, rsp_zero_length} !== e) begin
                  errors++;
                  $display("%0t mismatch expected x=%0d y=%0d z=%0d zero=%0b", $realtime,
                           $signed(e.x), $signed(e.y), $signed(e.z), e.zero);
                  $display("%0t          actual   x=%0d y=%0d z=%0d zero=%0b", $realtime,
                           rsp_x_out, rsp_y_out, rsp_z_out, rsp_zero_length);
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      vec_in_t v;
      logic [FW-1:0] mx, mn;
      mx = {1'b0, {(FW-1){1'b1}}};
      mn = {1'b1, {(FW-1){1'b0}}};
      // directed: zero, axes, extremes, mixed signs
      pending_vecs.push_back('{0, 0, 0});
      pending_vecs.push_back('{1, 0, 0});
      pending_vecs.push_back('{0, -1, 0});
      pending_vecs.push_back('{0, 0, 1});
      pending_vecs.push_back('{mx, 0, 0});
      pending_vecs.push_back('{mn, 0, 0});
      pending_vecs.push_back('{0, mn, 0});
      pending_vecs.push_back('{0, 0, mn});
      pending_vecs.push_back('{mx, mx, mx});
      pending_vecs.push_back('{mn, mn, mn});
      pending_vecs.push_back('{mx, mn, mx});
      pending_vecs.push_back('{1, 1, 1});
      pending_vecs.push_back('{-1, -1, -1});
      pending_vecs.push_back('{3, 4, 0});
      pending_vecs.push_back('{-3, 0, 4});
      pending_vecs.push_back('{mn, 1, -1});
      pending_vecs.push_back('{2, 3, 6});
      pending_vecs.push_back('{-24'sd12345, 24'sd6789, 24'sd1});
      pending_vecs.push_back('{0, 0, 0});
      pending_vecs.push_back('{FW'($urandom), FW'($urandom), FW'($urandom)});
      for (int i = 0; i < 1530; i++) begin
         v.x = rand_comp();
         v.y = rand_comp();
         v.z = rand_comp();
         pending_vecs.push_back(v);
      end
      repeat (12) @(posedge clock);
      reset <= 0;
      wait (pending_vecs.size() == 0 && !start);
      wait (expected_units.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_units.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

### files.f
sv/vn_pkg.sv
sv/vn_divider.sv
sv/vector3_normalize.sv
dv/testbench.sv
